@@ hdl/fresnel_reflectance_macros.svh @@
// Assertion macros shared by the checker files of the Fresnel reflectance block.
// No dependencies; every macro expects signals named clock and reset in scope.
`ifndef FRESNEL_REFLECTANCE_MACROS_SVH
`define FRESNEL_REFLECTANCE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FRESR_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define FRESR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define FRESR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/fresr_pkg.sv @@
// Package of the Fresnel reflectance block: payload types, widths and constants.
// Used by fresr_ratio, fresnel_reflectance and fresr_checker; no dependencies.
package fresr_pkg;

   // Field widths.
   localparam int IDX_W   = 15;
   localparam int CI_W    = 29;
   localparam int ETA2_W  = 30;
   localparam int LHS_W   = 59;
   localparam int PROD_W  = 44;
   localparam int Q_W     = 21;
   localparam int OUT_W   = 16;

   // Pipeline depths of the iterative sections.
   localparam int DIV_STEPS   = 28;
   localparam int SQRT_STEPS  = 29;
   localparam int RATIO_STEPS = 21;
   localparam int RATIO_LAT   = RATIO_STEPS + 1;

   // Constants.
   localparam logic [IDX_W-1:0] IDX_ONE   = 15'd4096;
   localparam logic [CI_W-1:0]  Q28_ONE   = 29'h1000_0000;
   localparam logic [Q_W-1:0]   RATIO_ONE = 21'h10_0000;
   localparam logic [OUT_W-1:0] OUT_ONE   = 16'h8000;

   // Input item.
   typedef struct packed {
      logic signed [15:0] incident_x;
      logic signed [15:0] incident_y;
      logic signed [15:0] incident_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [IDX_W-1:0]   refractive_index;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [OUT_W-1:0] reflectance;
      logic             total_internal;
   } rsp_type;

   // Per-item values that ride alongside the divider and square-root stages.
   typedef struct packed {
      logic             tir;
      logic [IDX_W-1:0] eta_i;
      logic [IDX_W-1:0] eta_t;
      logic [CI_W-1:0]  ci;
   } side_type;

endpackage

@@ hdl/fresr_ratio.sv @@
// Pipelined ratio |a - b| / (a + b) in Q.20, one quotient bit per stage.
// Depends on fresr_pkg for widths and the stage count.
module fresr_ratio (
   input  logic                          clock,
   input  logic                          en,
   input  logic [fresr_pkg::PROD_W-1:0]  a,
   input  logic [fresr_pkg::PROD_W-1:0]  b,
   output logic [fresr_pkg::Q_W-1:0]     q
);

   localparam int N = fresr_pkg::RATIO_STEPS;
   localparam int DW = fresr_pkg::PROD_W + 1;

   logic [DW:0]                  rem_ff [0:N];
   logic [DW:0]                  rem_in [0:N];
   logic [DW-1:0]                den_ff [0:N];
   logic [DW-1:0]                den_in [0:N];
   logic [fresr_pkg::Q_W-1:0]    q_ff   [0:N];
   logic [fresr_pkg::Q_W-1:0]    q_in   [0:N];
   logic                         zero_ff [0:N];
   logic                         zero_in [0:N];

   // Preparation: magnitude of the difference and the sum, then the long division steps.
   always_comb begin
      logic [fresr_pkg::PROD_W-1:0] num;
      logic [DW:0]                  sh;
      logic                         ge;
      num = (a >= b) ? (a - b) : (b - a);
      rem_in[0]  = {2'b00, num};
      den_in[0]  = {1'b0, a} + {1'b0, b};
      q_in[0]    = '0;
      zero_in[0] = (a == '0) && (b == '0);
      for (int k = 0; k < N; k++) begin
         sh = (k == 0) ? rem_ff[k] : {rem_ff[k][DW-1:0], 1'b0};
         ge = (sh >= {1'b0, den_ff[k]});
         rem_in[k+1]  = ge ? (sh - {1'b0, den_ff[k]}) : sh;
         den_in[k+1]  = den_ff[k];
         q_in[k+1]    = {q_ff[k][fresr_pkg::Q_W-2:0], ge};
         zero_in[k+1] = zero_ff[k];
      end
   end

   // Stage registers advance together with the rest of the pipeline.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= N; k++) begin
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= den_in[k];
            q_ff[k]    <= q_in[k];
            zero_ff[k] <= zero_in[k];
         end
      end
   end

   // Both terms zero gives a ratio of one.
   assign q = zero_ff[N] ? fresr_pkg::RATIO_ONE : q_ff[N];

endmodule

@@ hdl/fresnel_reflectance.sv @@
// Top level of the Fresnel reflectance pipeline for unpolarised light.
// Depends on fresr_pkg and instantiates fresr_ratio twice.
//
//   Channel | Ports                         | Moves
//   --------+-------------------------------+------------------------------------
//   req     | req_valid, req_ready, req_data| directions, normal and index
//   rsp     | rsp_valid, rsp_ready, rsp_data| reflectance and total-internal flag
//
// One item enters per cycle while no result waits untaken; the pipeline holds
// the 28-step divider, the 29-step square root and the 21-step ratio dividers.
// Synchronous reset clears only the valid bits; no clearing pass is needed.
// A result not taken stalls the whole pipeline, and nothing is lost or repeated.
module fresnel_reflectance (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fresr_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fresr_pkg::rsp_type  rsp_data
);

   localparam int ND = fresr_pkg::DIV_STEPS;
   localparam int NS = fresr_pkg::SQRT_STEPS;
   localparam int NR = fresr_pkg::RATIO_LAT;

   logic en;

   // Stage 1: the three component products.
   logic               s1_vld_ff;
   logic signed [31:0] s1_p0_ff, s1_p1_ff, s1_p2_ff;
   logic [14:0]        s1_n_ff, s1_n_in;

   // Stage 2: clamped cosine and media indices.
   logic               s2_vld_ff;
   fresr_pkg::side_type s2_side_ff, s2_side_in;

   // Stage 3: cosine squared.
   logic               s3_vld_ff;
   fresr_pkg::side_type s3_side_ff;
   logic [28:0]        s3_c2_ff;

   // Stage 4: sine squared and squared indices.
   logic               s4_vld_ff;
   fresr_pkg::side_type s4_side_ff;
   logic [28:0]        s4_s2_ff;
   logic [29:0]        s4_eti2_ff, s4_ett2_ff;

   // Stage 5: scaled sine squared.
   logic               s5_vld_ff;
   fresr_pkg::side_type s5_side_ff;
   logic [58:0]        s5_lhs_ff;
   logic [29:0]        s5_ett2_ff;

   // Divider stages for the refracted sine squared.
   logic                dv_vld_ff  [0:ND];
   logic                dv_vld_in  [0:ND];
   logic [30:0]         dv_rem_ff  [0:ND];
   logic [30:0]         dv_rem_in  [0:ND];
   logic [27:0]         dv_low_ff  [0:ND];
   logic [27:0]         dv_low_in  [0:ND];
   logic [29:0]         dv_d_ff    [0:ND];
   logic [29:0]         dv_d_in    [0:ND];
   logic [27:0]         dv_q_ff    [0:ND];
   logic [27:0]         dv_q_in    [0:ND];
   fresr_pkg::side_type dv_side_ff [0:ND];
   fresr_pkg::side_type dv_side_in [0:ND];

   // Square-root stages for the refracted cosine.
   logic                sq_vld_ff  [0:NS];
   logic                sq_vld_in  [0:NS];
   logic [57:0]         sq_v_ff    [0:NS];
   logic [57:0]         sq_v_in    [0:NS];
   logic [31:0]         sq_rem_ff  [0:NS];
   logic [31:0]         sq_rem_in  [0:NS];
   logic [28:0]         sq_root_ff [0:NS];
   logic [28:0]         sq_root_in [0:NS];
   fresr_pkg::side_type sq_side_ff [0:NS];
   fresr_pkg::side_type sq_side_in [0:NS];

   // Cross products feeding the two ratio dividers.
   logic                pr_vld_ff, pr_tir_ff;
   logic [43:0]         pr_a_ff, pr_b_ff, pr_c_ff, pr_d_ff;

   // Valid and flag alongside the ratio dividers.
   logic                rt_vld_ff [0:NR-1];
   logic                rt_tir_ff [0:NR-1];
   logic [20:0]         rp, rs;

   // Squares of the two ratios.
   logic                qs_vld_ff, qs_tir_ff;
   logic [41:0]         qs_p_ff, qs_s_ff;

   // Output register.
   logic                out_vld_ff;
   fresr_pkg::rsp_type  out_data_ff, out_data_in;

   // The whole pipeline advances unless a result waits untaken.
   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   // Index clamp to at least one.
   assign s1_n_in = (req_data.refractive_index < fresr_pkg::IDX_ONE) ?
                    fresr_pkg::IDX_ONE : req_data.refractive_index;

   // Dot product, clamp and choice of media.
   always_comb begin
      logic signed [33:0] dot;
      logic [33:0]        mag;
      dot = 34'(s1_p0_ff) + 34'(s1_p1_ff) + 34'(s1_p2_ff);
      mag = dot[33] ? 34'(-dot) : 34'(dot);
      s2_side_in.tir = 1'b0;
      s2_side_in.ci  = (mag > 34'(fresr_pkg::Q28_ONE)) ? fresr_pkg::Q28_ONE : mag[28:0];
      if (!dot[33] && (dot != '0)) begin
         s2_side_in.eta_i = s1_n_ff;
         s2_side_in.eta_t = fresr_pkg::IDX_ONE;
      end else begin
         s2_side_in.eta_i = fresr_pkg::IDX_ONE;
         s2_side_in.eta_t = s1_n_ff;
      end
   end

   // Front stages.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_p0_ff   <= $signed(req_data.incident_x) * $signed(req_data.normal_x);
         s1_p1_ff   <= $signed(req_data.incident_y) * $signed(req_data.normal_y);
         s1_p2_ff   <= $signed(req_data.incident_z) * $signed(req_data.normal_z);
         s1_n_ff    <= s1_n_in;
         s2_side_ff <= s2_side_in;
         s3_side_ff <= s2_side_ff;
         s3_c2_ff   <= 29'((58'(s2_side_ff.ci) * 58'(s2_side_ff.ci)) >> 28);
         s4_side_ff <= s3_side_ff;
         s4_s2_ff   <= fresr_pkg::Q28_ONE - s3_c2_ff;
         s4_eti2_ff <= 30'(s3_side_ff.eta_i) * 30'(s3_side_ff.eta_i);
         s4_ett2_ff <= 30'(s3_side_ff.eta_t) * 30'(s3_side_ff.eta_t);
         s5_side_ff <= s4_side_ff;
         s5_lhs_ff  <= 59'(s4_eti2_ff) * 59'(s4_s2_ff);
         s5_ett2_ff <= s4_ett2_ff;
      end
   end

   // Total internal reflection test and the long division of the sine squared.
   always_comb begin
      logic [30:0] sh;
      logic        ge;
      dv_vld_in[0]      = s5_vld_ff;
      dv_rem_in[0]      = s5_lhs_ff[58:28];
      dv_low_in[0]      = s5_lhs_ff[27:0];
      dv_d_in[0]        = s5_ett2_ff;
      dv_q_in[0]        = '0;
      dv_side_in[0]     = s5_side_ff;
      dv_side_in[0].tir = (s5_lhs_ff >= {1'b0, s5_ett2_ff, 28'd0});
      for (int k = 0; k < ND; k++) begin
         sh = {dv_rem_ff[k][29:0], dv_low_ff[k][27]};
         ge = (sh >= {1'b0, dv_d_ff[k]});
         dv_vld_in[k+1]  = dv_vld_ff[k];
         dv_rem_in[k+1]  = ge ? (sh - {1'b0, dv_d_ff[k]}) : sh;
         dv_low_in[k+1]  = {dv_low_ff[k][26:0], 1'b0};
         dv_d_in[k+1]    = dv_d_ff[k];
         dv_q_in[k+1]    = {dv_q_ff[k][26:0], ge};
         dv_side_in[k+1] = dv_side_ff[k];
      end
   end

   // Square root of the cosine squared, two radicand bits per stage.
   always_comb begin
      logic [31:0] sh;
      logic [31:0] trial;
      logic        ge;
      logic [28:0] u;
      u              = fresr_pkg::Q28_ONE - 29'(dv_q_ff[ND]);
      sq_vld_in[0]   = dv_vld_ff[ND];
      sq_v_in[0]     = {1'b0, u, 28'd0};
      sq_rem_in[0]   = '0;
      sq_root_in[0]  = '0;
      sq_side_in[0]  = dv_side_ff[ND];
      for (int j = 0; j < NS; j++) begin
         sh    = {sq_rem_ff[j][29:0], sq_v_ff[j][57:56]};
         trial = {1'b0, sq_root_ff[j], 2'b01};
         ge    = (sh >= trial);
         sq_vld_in[j+1]  = sq_vld_ff[j];
         sq_v_in[j+1]    = {sq_v_ff[j][55:0], 2'b00};
         sq_rem_in[j+1]  = ge ? (sh - trial) : sh;
         sq_root_in[j+1] = {sq_root_ff[j][27:0], ge};
         sq_side_in[j+1] = sq_side_ff[j];
      end
   end

   // Payload of the divider, square-root and back stages.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= ND; k++) begin
            dv_rem_ff[k]  <= dv_rem_in[k];
            dv_low_ff[k]  <= dv_low_in[k];
            dv_d_ff[k]    <= dv_d_in[k];
            dv_q_ff[k]    <= dv_q_in[k];
            dv_side_ff[k] <= dv_side_in[k];
         end
         for (int j = 0; j <= NS; j++) begin
            sq_v_ff[j]    <= sq_v_in[j];
            sq_rem_ff[j]  <= sq_rem_in[j];
            sq_root_ff[j] <= sq_root_in[j];
            sq_side_ff[j] <= sq_side_in[j];
         end
         pr_tir_ff <= sq_side_ff[NS].tir;
         pr_a_ff   <= 44'(sq_side_ff[NS].eta_t) * 44'(sq_side_ff[NS].ci);
         pr_b_ff   <= 44'(sq_side_ff[NS].eta_i) * 44'(sq_root_ff[NS]);
         pr_c_ff   <= 44'(sq_side_ff[NS].eta_t) * 44'(sq_root_ff[NS]);
         pr_d_ff   <= 44'(sq_side_ff[NS].eta_i) * 44'(sq_side_ff[NS].ci);
         rt_tir_ff[0] <= pr_tir_ff;
         for (int r = 1; r < NR; r++) begin
            rt_tir_ff[r] <= rt_tir_ff[r-1];
         end
         qs_tir_ff   <= rt_tir_ff[NR-1];
         qs_p_ff     <= 42'(rp) * 42'(rp);
         qs_s_ff     <= 42'(rs) * 42'(rs);
         out_data_ff <= out_data_in;
      end
   end

   // Parallel and perpendicular ratios.
   fresr_ratio u_rp (
      .clock (clock),
      .en    (en),
      .a     (pr_a_ff),
      .b     (pr_b_ff),
      .q     (rp)
   );

   fresr_ratio u_rs (
      .clock (clock),
      .en    (en),
      .a     (pr_c_ff),
      .b     (pr_d_ff),
      .q     (rs)
   );

   // Mean of the squares, saturated, or one on total internal reflection.
   always_comb begin
      logic [42:0] sum;
      logic [16:0] r;
      sum = {1'b0, qs_p_ff} + {1'b0, qs_s_ff};
      r   = sum[42:26];
      if (qs_tir_ff) begin
         out_data_in.reflectance    = fresr_pkg::OUT_ONE;
         out_data_in.total_internal = 1'b1;
      end else begin
         out_data_in.reflectance    = (r > 17'(fresr_pkg::OUT_ONE)) ?
                                      fresr_pkg::OUT_ONE : r[15:0];
         out_data_in.total_internal = 1'b0;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         for (int k = 0; k <= ND; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
         for (int j = 0; j <= NS; j++) begin
            sq_vld_ff[j] <= 1'b0;
         end
         pr_vld_ff  <= 1'b0;
         for (int r = 0; r < NR; r++) begin
            rt_vld_ff[r] <= 1'b0;
         end
         qs_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= req_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         for (int k = 0; k <= ND; k++) begin
            dv_vld_ff[k] <= dv_vld_in[k];
         end
         for (int j = 0; j <= NS; j++) begin
            sq_vld_ff[j] <= sq_vld_in[j];
         end
         pr_vld_ff    <= sq_vld_ff[NS];
         rt_vld_ff[0] <= pr_vld_ff;
         for (int r = 1; r < NR; r++) begin
            rt_vld_ff[r] <= rt_vld_ff[r-1];
         end
         qs_vld_ff  <= rt_vld_ff[NR-1];
         out_vld_ff <= qs_vld_ff;
      end
   end

endmodule

@@ hdl/fresr_checker.sv @@
// Port-level checker for the Fresnel reflectance block, bound to the top level.
// Depends on fresr_pkg and fresnel_reflectance_macros.svh.
`include "fresnel_reflectance_macros.svh"

module fresr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input fresr_pkg::rsp_type rsp_data
);

   logic tir_full_ok;
   logic in_range;
   logic rsp_stalled;

   // Conditions shown on the result port.
   assign tir_full_ok = !rsp_data.total_internal ||
                        (rsp_data.reflectance == fresr_pkg::OUT_ONE);
   assign in_range    = (rsp_data.reflectance <= fresr_pkg::OUT_ONE);
   assign rsp_stalled = rsp_valid && !rsp_ready;

   // Total internal reflection always reports full reflectance.
   `FRESR_ASSERT_IMP(a_tir_full, rsp_valid, tir_full_ok, "flagged result below one")

   // Reflectance never exceeds one.
   `FRESR_ASSERT_IMP(a_sat, rsp_valid, in_range, "reflectance above one")

   // A waiting result stalls the input side.
   `FRESR_ASSERT_IMP(a_stall_in, rsp_stalled, !req_ready, "input taken while a result waits")

   // A result not taken stays put.
   `FRESR_ASSERT_NXT(a_hold, rsp_stalled, rsp_valid && $stable(rsp_data), "waiting result changed")

endmodule

bind fresnel_reflectance fresr_checker u_fresr_checker (.*);
